// File: hw/rtl/rpa_pkg.sv
// ----------------------------------------------------------------------------
// rpa_pkg
// Shared widths, stage numbering, cordic arctangent table, stage record and
// rounding helpers for the point rotation pipeline
// ----------------------------------------------------------------------------
package rpa_pkg;

    localparam int COORD_W       = 32;
    localparam int AXIS_W        = 16;
    localparam int ANGLE_W       = 16;
    localparam int AXIS_FRAC     = AXIS_W - 2;
    localparam int TRIG_FRAC     = 30;
    localparam int CORDIC_STEPS  = 24;
    localparam int VEC_W         = 40;
    localparam int CORD_W        = 34;
    localparam int ZW            = 32;
    localparam int SUM_W         = 42;
    localparam int SPLIT_W       = 20;
    localparam int PA_W          = VEC_W + AXIS_W;
    localparam int PT_W          = SPLIT_W + 1 + CORD_W;
    localparam int TP_W          = VEC_W + CORD_W;
    localparam int TURN_UNITS    = 23040;
    localparam int QUARTER_UNITS = 5760;
    localparam int IN_W          = 160;
    localparam int OUT_W         = 104;

    localparam int ST_IN       = 0;
    localparam int ST_ANGLE    = 1;
    localparam int ST_CORDIC0  = 2;
    localparam int ST_K        = 2;
    localparam int ST_P_MUL    = 3;
    localparam int ST_R        = 4;
    localparam int ST_X_MUL    = 5;
    localparam int ST_X        = 6;
    localparam int ST_QUAD     = ST_CORDIC0 + CORDIC_STEPS;
    localparam int ST_T_MUL    = ST_QUAD + 1;
    localparam int ST_T_RND    = ST_QUAD + 2;
    localparam int ST_OUT      = ST_QUAD + 3;
    localparam int NUM_STAGES  = ST_OUT + 1;

    localparam logic signed [CORD_W-1:0] GAIN_INV = 34'sd652032874;

    localparam logic signed [ZW-1:0] ATAN_TABLE [CORDIC_STEPS] = '{
        32'sd188743680, 32'sd111421900, 32'sd58872272, 32'sd29884485,
        32'sd15000234,  32'sd7507429,   32'sd3754631,  32'sd1877430,
        32'sd938729,    32'sd469366,    32'sd234683,   32'sd117342,
        32'sd58671,     32'sd29335,     32'sd14668,    32'sd7334,
        32'sd3667,      32'sd1833,      32'sd917,      32'sd458,
        32'sd229,       32'sd115,       32'sd57,       32'sd29
    };

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    typedef struct packed {
        logic [2:0][AXIS_W-1:0]  n;
        logic [2:0][COORD_W-1:0] v;
        logic [ANGLE_W-1:0]      ang;
        logic [1:0]              quad;
        logic signed [CORD_W-1:0] cor_x;
        logic signed [CORD_W-1:0] cor_y;
        logic signed [ZW-1:0]     cor_z;
        logic [5:0][PA_W-1:0]    pa;
        logic signed [VEC_W-1:0] k;
        logic [2:0][VEC_W-1:0]   p;
        logic [2:0][VEC_W-1:0]   r;
        logic [2:0][VEC_W-1:0]   q;
        logic signed [CORD_W-1:0] sn;
        logic signed [CORD_W-1:0] cs;
        logic [5:0][PT_W-1:0]    ph;
        logic [5:0][PT_W-1:0]    pl;
        logic [5:0][SUM_W-1:0]   tt;
        logic [2:0][COORD_W-1:0] rot;
        logic                    clip;
    } stage_t;

    // round to nearest, ties away from zero
    function automatic logic signed [VEC_W-1:0] rnd_axis(input logic signed [PA_W-1:0] p);
        logic signed [PA_W-1:0] t;
        t = p + (PA_W'(1) <<< (AXIS_FRAC - 1)) - PA_W'(p[PA_W-1]);
        return VEC_W'(t >>> AXIS_FRAC);
    endfunction

    function automatic logic signed [SUM_W-1:0] rnd_trig(input logic signed [TP_W-1:0] p);
        logic signed [TP_W-1:0] t;
        t = p + (TP_W'(1) <<< (TRIG_FRAC - 1)) - TP_W'(p[TP_W-1]);
        return SUM_W'(t >>> TRIG_FRAC);
    endfunction

endpackage

// File: hw/rtl/rotate_point_about_axis.sv
// ----------------------------------------------------------------------------
// rotate_point_about_axis
// Rodrigues rotation of a Q16.16 point about a Q2.14 axis by an angle in
// 1/64 degree, with a 24-step cordic for sine and cosine
// ----------------------------------------------------------------------------
// throughput: one item per cycle while m_tready is not held low, set by the 24-stage cordic
// chain and the split 40x34 trig multipliers, each stage holding its own item
// a stage moves whenever the one after it is empty or moving
// reset clears every stage valid bit; data registers are not reset
module rotate_point_about_axis import rpa_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    // axis_x, axis_y, axis_z, point_x, point_y, point_z, angle
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // rotated_x, rotated_y, rotated_z, clipped, zero fill
    output logic [OUT_W-1:0] m_tdata
);

    localparam logic signed [SUM_W-1:0] SAT_HI = (SUM_W'(1) <<< (COORD_W - 1)) - SUM_W'(1);
    localparam logic signed [SUM_W-1:0] SAT_LO = -(SUM_W'(1) <<< (COORD_W - 1));

    stage_t                  st_reg [NUM_STAGES];
    logic [NUM_STAGES-1:0]   valid_reg;
    logic [NUM_STAGES:0]     ready;
    stage_t                  in_next;

    assign ready[NUM_STAGES] = m_tready;
    assign s_tready          = ready[ST_IN];
    assign m_tvalid          = valid_reg[ST_OUT];
    assign m_tdata           = {7'b0, st_reg[ST_OUT].clip, st_reg[ST_OUT].rot[2],
                                st_reg[ST_OUT].rot[1], st_reg[ST_OUT].rot[0]};

    always_comb begin
        in_next      = '0;
        in_next.n[0] = s_tdata[15:0];
        in_next.n[1] = s_tdata[31:16];
        in_next.n[2] = s_tdata[47:32];
        in_next.v[0] = s_tdata[79:48];
        in_next.v[1] = s_tdata[111:80];
        in_next.v[2] = s_tdata[143:112];
        in_next.ang  = s_tdata[159:144];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg[ST_IN] <= 1'b0;
        end else if (ready[ST_IN]) begin
            valid_reg[ST_IN] <= s_tvalid;
        end
        if (ready[ST_IN] && s_tvalid) begin
            st_reg[ST_IN] <= in_next;
        end
    end

    for (genvar j = 0; j < NUM_STAGES; j++) begin : g_ready
        assign ready[j] = !valid_reg[j] || ready[j+1];
    end

    for (genvar j = 1; j < NUM_STAGES; j++) begin : g_stage
        localparam int CI = (j >= ST_CORDIC0 && j < ST_CORDIC0 + CORDIC_STEPS) ?
                            j - ST_CORDIC0 : 0;
        stage_t stage_next;

        always_comb begin
            stage_t                  prv;
            logic signed [ANGLE_W:0] m;
            logic signed [ANGLE_W:0] base;
            logic signed [VEC_W-1:0] a;
            logic signed [CORD_W-1:0] b;
            logic signed [SUM_W-1:0] sum;
            prv        = st_reg[j-1];
            stage_next = prv;
            m          = '0;
            base       = '0;
            a          = '0;
            b          = '0;
            sum        = '0;
            if (j == ST_ANGLE) begin
                m = {prv.ang[ANGLE_W-1], prv.ang};
                if (m >= (ANGLE_W+1)'(TURN_UNITS)) begin
                    m = m - (ANGLE_W+1)'(TURN_UNITS);
                end else if (m < -(ANGLE_W+1)'(TURN_UNITS)) begin
                    m = m + (ANGLE_W+1)'(2 * TURN_UNITS);
                end else if (m < 0) begin
                    m = m + (ANGLE_W+1)'(TURN_UNITS);
                end
                if (m >= (ANGLE_W+1)'(3 * QUARTER_UNITS)) begin
                    stage_next.quad = QUAD_3;
                    base = (ANGLE_W+1)'(3 * QUARTER_UNITS);
                end else if (m >= (ANGLE_W+1)'(2 * QUARTER_UNITS)) begin
                    stage_next.quad = QUAD_2;
                    base = (ANGLE_W+1)'(2 * QUARTER_UNITS);
                end else if (m >= (ANGLE_W+1)'(QUARTER_UNITS)) begin
                    stage_next.quad = QUAD_1;
                    base = (ANGLE_W+1)'(QUARTER_UNITS);
                end else begin
                    stage_next.quad = QUAD_0;
                end
                stage_next.cor_z = ZW'(m - base) <<< 16;
                stage_next.cor_x = GAIN_INV;
                stage_next.cor_y = '0;
                for (int c = 0; c < 3; c++) begin
                    stage_next.pa[c] = PA_W'($signed(prv.v[c]) * $signed(prv.n[c]));
                end
            end
            if (j >= ST_CORDIC0 && j < ST_CORDIC0 + CORDIC_STEPS) begin
                if (prv.cor_z >= 0) begin
                    stage_next.cor_x = prv.cor_x - (prv.cor_y >>> CI);
                    stage_next.cor_y = prv.cor_y + (prv.cor_x >>> CI);
                    stage_next.cor_z = prv.cor_z - ATAN_TABLE[CI];
                end else begin
                    stage_next.cor_x = prv.cor_x + (prv.cor_y >>> CI);
                    stage_next.cor_y = prv.cor_y - (prv.cor_x >>> CI);
                    stage_next.cor_z = prv.cor_z + ATAN_TABLE[CI];
                end
            end
            if (j == ST_K) begin
                stage_next.k = rnd_axis($signed(prv.pa[0])) + rnd_axis($signed(prv.pa[1]))
                             + rnd_axis($signed(prv.pa[2]));
            end
            if (j == ST_P_MUL) begin
                for (int c = 0; c < 3; c++) begin
                    stage_next.pa[c] = PA_W'(prv.k * $signed(prv.n[c]));
                end
            end
            if (j == ST_R) begin
                for (int c = 0; c < 3; c++) begin
                    stage_next.p[c] = rnd_axis($signed(prv.pa[c]));
                    stage_next.r[c] = VEC_W'($signed(prv.v[c])) - rnd_axis($signed(prv.pa[c]));
                end
            end
            if (j == ST_X_MUL) begin
                stage_next.pa[0] = PA_W'($signed(prv.r[2]) * $signed(prv.n[1]));
                stage_next.pa[1] = PA_W'($signed(prv.r[1]) * $signed(prv.n[2]));
                stage_next.pa[2] = PA_W'($signed(prv.r[0]) * $signed(prv.n[2]));
                stage_next.pa[3] = PA_W'($signed(prv.r[2]) * $signed(prv.n[0]));
                stage_next.pa[4] = PA_W'($signed(prv.r[1]) * $signed(prv.n[0]));
                stage_next.pa[5] = PA_W'($signed(prv.r[0]) * $signed(prv.n[1]));
            end
            if (j == ST_X) begin
                for (int c = 0; c < 3; c++) begin
                    stage_next.q[c] = rnd_axis($signed(prv.pa[2*c]))
                                    - rnd_axis($signed(prv.pa[2*c+1]));
                end
            end
            if (j == ST_QUAD) begin
                case (prv.quad)
                    QUAD_0: begin
                        stage_next.cs = prv.cor_x;
                        stage_next.sn = prv.cor_y;
                    end
                    QUAD_1: begin
                        stage_next.cs = -prv.cor_y;
                        stage_next.sn = prv.cor_x;
                    end
                    QUAD_2: begin
                        stage_next.cs = -prv.cor_x;
                        stage_next.sn = -prv.cor_y;
                    end
                    default: begin
                        stage_next.cs = prv.cor_y;
                        stage_next.sn = -prv.cor_x;
                    end
                endcase
            end
            if (j == ST_T_MUL) begin
                for (int t = 0; t < 6; t++) begin
                    a = (t % 2 == 0) ? $signed(prv.r[t/2]) : $signed(prv.q[t/2]);
                    b = (t % 2 == 0) ? prv.cs : prv.sn;
                    stage_next.ph[t] = PT_W'($signed(a[VEC_W-1:SPLIT_W]) * b);
                    stage_next.pl[t] = PT_W'($signed({1'b0, a[SPLIT_W-1:0]}) * b);
                end
            end
            if (j == ST_T_RND) begin
                for (int t = 0; t < 6; t++) begin
                    stage_next.tt[t] = rnd_trig((TP_W'($signed(prv.ph[t])) <<< SPLIT_W)
                                                + TP_W'($signed(prv.pl[t])));
                end
            end
            if (j == ST_OUT) begin
                stage_next.clip = 1'b0;
                for (int c = 0; c < 3; c++) begin
                    sum = $signed(prv.tt[2*c]) + $signed(prv.tt[2*c+1])
                        + SUM_W'($signed(prv.p[c]));
                    if (sum > SAT_HI) begin
                        stage_next.rot[c] = COORD_W'(SAT_HI);
                        stage_next.clip   = 1'b1;
                    end else if (sum < SAT_LO) begin
                        stage_next.rot[c] = COORD_W'(SAT_LO);
                        stage_next.clip   = 1'b1;
                    end else begin
                        stage_next.rot[c] = COORD_W'(sum);
                    end
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[j] <= 1'b0;
            end else if (ready[j]) begin
                valid_reg[j] <= valid_reg[j-1];
            end
            if (ready[j] && valid_reg[j-1]) begin
                st_reg[j] <= stage_next;
            end
        end
    end

endmodule

// File: hw/rtl/rpa_checker.sv
// ----------------------------------------------------------------------------
// rpa_props
// Port-level checks on the point rotation pipeline, bound to the top level
// ----------------------------------------------------------------------------
module rpa_props import rpa_pkg::*; (
    input logic             aclk,
    input logic             aresetn,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic [IN_W-1:0]  s_tdata,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata
);

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input stalled while output drains");

    a_clip: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[96] |->
            (m_tdata[31:0] == 32'h7fffffff) || (m_tdata[31:0] == 32'h80000000) ||
            (m_tdata[63:32] == 32'h7fffffff) || (m_tdata[63:32] == 32'h80000000) ||
            (m_tdata[95:64] == 32'h7fffffff) || (m_tdata[95:64] == 32'h80000000))
        else $error("clip flag without a saturated component");

endmodule

bind rotate_point_about_axis rpa_props u_rpa_props (.*);

// File: sim/rpa_checker.sv
// ----------------------------------------------------------------------------
// rpa_checker
// Watches both stream channels of the point rotation block, computes the
// rotated point for every accepted input and compares it with each result
// ----------------------------------------------------------------------------
module rpa_checker import rpa_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    input  logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,
    input  logic             m_tvalid,
    input  logic             m_tready,
    input  logic [OUT_W-1:0] m_tdata,
    output int               err_count,
    output int               pending,
    output int               rot_count,
    output int               clip_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                     clip;
        logic [2:0][COORD_W-1:0]  rot;
    } rotated_t;

    rotated_t rotated_q[$];

    localparam longint ATAN_DEG [CORDIC_STEPS] = '{
        188743680, 111421900, 58872272, 29884485, 15000234, 7507429,
        3754631, 1877430, 938729, 469366, 234683, 117342,
        58671, 29335, 14668, 7334, 3667, 1833,
        917, 458, 229, 115, 57, 29
    };

    function automatic longint scale_round(longint a, longint b, int sh);
        logic         neg;
        logic [127:0] mag;
        neg = (a < 0) != (b < 0);
        mag = 128'(a < 0 ? -a : a) * 128'(b < 0 ? -b : b);
        mag = (mag + (128'(1) << (sh - 1))) >> sh;
        return neg ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic void trig_of(longint ang, output longint sn, output longint cs);
        longint m, x, y, z, dx, dy;
        int     q;
        m = ang % TURN_UNITS;
        if (m < 0) m += TURN_UNITS;
        q = int'(m / QUARTER_UNITS);
        z = (m % QUARTER_UNITS) * 65536;
        x = 652032874;
        y = 0;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= ATAN_DEG[i];
            end else begin
                x += dx; y -= dy; z += ATAN_DEG[i];
            end
        end
        case (q)
            QUAD_0: begin cs = x;  sn = y;  end
            QUAD_1: begin cs = -y; sn = x;  end
            QUAD_2: begin cs = -x; sn = -y; end
            default: begin cs = y; sn = -x; end
        endcase
    endfunction

    function automatic rotated_t rotate_point(logic [IN_W-1:0] d);
        longint   n [3];
        longint   v [3];
        longint   p [3];
        longint   r [3];
        longint   c [3];
        longint   k, sn, cs, t, hi, lo;
        rotated_t res;
        for (int i = 0; i < 3; i++) begin
            n[i] = longint'($signed(d[i*AXIS_W +: AXIS_W]));
            v[i] = longint'($signed(d[3*AXIS_W + i*COORD_W +: COORD_W]));
        end
        trig_of(longint'($signed(d[3*AXIS_W + 3*COORD_W +: ANGLE_W])), sn, cs);
        k = 0;
        for (int i = 0; i < 3; i++) k += scale_round(v[i], n[i], AXIS_FRAC);
        for (int i = 0; i < 3; i++) begin
            p[i] = scale_round(k, n[i], AXIS_FRAC);
            r[i] = v[i] - p[i];
        end
        c[0] = scale_round(r[2], n[1], AXIS_FRAC) - scale_round(r[1], n[2], AXIS_FRAC);
        c[1] = scale_round(r[0], n[2], AXIS_FRAC) - scale_round(r[2], n[0], AXIS_FRAC);
        c[2] = scale_round(r[1], n[0], AXIS_FRAC) - scale_round(r[0], n[1], AXIS_FRAC);
        hi = (longint'(1) <<< (COORD_W - 1)) - 1;
        lo = -hi - 1;
        res.clip = 1'b0;
        for (int i = 0; i < 3; i++) begin
            t = scale_round(r[i], cs, TRIG_FRAC) + scale_round(c[i], sn, TRIG_FRAC) + p[i];
            if (t > hi) begin t = hi; res.clip = 1'b1; end
            if (t < lo) begin t = lo; res.clip = 1'b1; end
            res.rot[i] = t[COORD_W-1:0];
        end
        return res;
    endfunction

    initial begin
        err_count = 0;
        rot_count = 0;
        clip_count = 0;
        pending = 0;
    end

    always @(posedge aclk) begin
        rotated_t want, got;
        if (aresetn && s_tvalid && s_tready) rotated_q.push_back(rotate_point(s_tdata));
        if (aresetn && m_tvalid && m_tready) begin
            got.rot  = m_tdata[3*COORD_W-1:0];
            got.clip = m_tdata[3*COORD_W];
            rot_count++;
            if (got.clip) clip_count++;
            if (rotated_q.size() == 0) begin
                err_count++;
                $display("%0t: result with nothing expected, actual %h", $time, got);
            end else begin
                want = rotated_q.pop_front();
                for (int i = 0; i < 3; i++)
                    if (got.rot[i] !== want.rot[i]) begin
                        err_count++;
                        $display("%0t: rotated[%0d] expected %h actual %h",
                                 $time, i, want.rot[i], got.rot[i]);
                    end
                if (got.clip !== want.clip) begin
                    err_count++;
                    $display("%0t: clipped expected %b actual %b", $time, want.clip, got.clip);
                end
            end
        end
        pending = rotated_q.size();
    end

endmodule

// File: sim/tb_rotate_point_about_axis.sv
// ----------------------------------------------------------------------------
// tb_rotate_point_about_axis
// Drives axis, point and angle items into the rotation pipeline with random
// gaps and result stalls; a separate checker predicts and compares results
// ----------------------------------------------------------------------------
module tb_rotate_point_about_axis import rpa_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT = 400000;
    localparam int UNIT  = 16384;

    logic             aclk;
    logic             aresetn;
    logic             s_tvalid;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata;
    logic             m_tvalid;
    logic             m_tready;
    logic [OUT_W-1:0] m_tdata;
    int               err_count, pending, rot_count, clip_count;
    int               cycles;
    logic             stim_done;

    rotate_point_about_axis i_dut (.*);

    rpa_checker i_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("simulation failed");
            $finish;
        end
    end

    function automatic logic [IN_W-1:0] pack_item(logic [15:0] ax, logic [15:0] ay,
            logic [15:0] az, logic [31:0] px, logic [31:0] py, logic [31:0] pz,
            logic [15:0] ang);
        return IN_W'({ang, pz, py, px, az, ay, ax});
    endfunction

    task automatic send_item(logic [IN_W-1:0] d);
        int gap;
        gap = int'($urandom_range(0, 10));
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  <= d;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic send_burst(logic [IN_W-1:0] d);
        s_tdata  <= d;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    function automatic logic [15:0] unit_axis();
        case ($urandom_range(0, 5))
            0: return 16'(UNIT);
            1: return 16'(-UNIT);
            2: return 16'(11585);
            3: return 16'(-9459);
            4: return 16'($urandom_range(0, 2 * UNIT) - UNIT);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 4))
            0: return 32'($urandom_range(0, 1 << 20) - (1 << 19));
            1: return 32'h7fff_ffff;
            2: return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] rand_angle();
        case ($urandom_range(0, 5))
            0: return 16'($urandom_range(0, 46080) - 23040);
            1: return 16'(5760 * $urandom_range(0, 4));
            2: return 16'($urandom);
            default: return 16'($urandom_range(0, 4000) - 2000);
        endcase
    endfunction

    function automatic logic [IN_W-1:0] rand_item();
        return pack_item(unit_axis(), unit_axis(), unit_axis(), rand_coord(),
                         rand_coord(), rand_coord(), rand_angle());
    endfunction

    initial begin
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        aresetn   = 1'b0;
        cycles    = 0;
        stim_done = 1'b0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        // directed: extremes, quadrants, zero and non-unit axis, on-axis point
        send_item(pack_item(16'(UNIT), 0, 0, 32'h0001_0000, 32'h0002_0000, 0, 16'(5760)));
        send_item(pack_item(0, 16'(UNIT), 0, 32'h0001_0000, 0, 32'h0001_0000, 16'(11520)));
        send_item(pack_item(0, 0, 16'(UNIT), 32'h0003_0000, 32'h0001_0000, 0, 16'(17280)));
        send_item(pack_item(0, 0, 16'(-UNIT), 32'h0003_0000, 32'h0001_0000, 0, 16'(-5760)));
        send_item(pack_item(0, 0, 0, 32'h1234_5678, 32'h8765_4321, 32'h0f0f_0f0f, 16'(1000)));
        send_item(pack_item(16'(UNIT), 0, 0, 32'h0005_0000, 0, 0, 16'(3000)));
        send_item(pack_item(16'h7fff, 16'h7fff, 16'h7fff, 32'h7fff_ffff, 32'h7fff_ffff,
                            32'h7fff_ffff, 16'h7fff));
        send_item(pack_item(16'h8000, 16'h8000, 16'h8000, 32'h8000_0000, 32'h8000_0000,
                            32'h8000_0000, 16'h8000));
        send_item(pack_item(0, 0, 16'(UNIT), 32'h7fff_ffff, 32'h7fff_ffff, 0, 16'(2880)));
        send_item(pack_item(16'(UNIT), 0, 0, 0, 32'h8000_0000, 32'h8000_0000, 16'(-2880)));
        send_item(pack_item(16'hffff, 16'hffff, 16'hffff, 32'hffff_ffff, 32'hffff_ffff,
                            32'hffff_ffff, 16'hffff));
        send_item(pack_item(16'(11585), 16'(11585), 0, 32'h0001_0000, 32'h0001_0000,
                            32'h0001_0000, 16'(23040)));
        send_item(pack_item(16'(9459), 16'(9459), 16'(9459), 32'h0100_0000,
                            32'hff00_0000, 32'h0000_8000, 16'(-23040)));
        send_item(pack_item(16'(UNIT), 0, 0, 32'h0001_0000, 32'h0001_0000, 0, 16'(1)));
        s_tvalid <= 1'b0;
        // hold off until the pipeline has drained
        while (pending != 0) @(negedge aclk);
        for (int i = 0; i < 450; i++) begin
            if ($urandom_range(0, 3) == 0) send_burst(rand_item());
            else send_item(rand_item());
            if (i % 100 == 50) begin
                for (int j = 0; j < 20; j++) send_burst(rand_item());
            end
        end
        s_tvalid  <= 1'b0;
        stim_done = 1'b1;
        while (pending != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
        $display("checked %0d rotated points, %0d with clipping", rot_count, clip_count);
        if (err_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        int gap;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (!stim_done && cycles % 3000 < 600) begin
                m_tready <= 1'b1;
            end else begin
                gap = int'($urandom_range(0, 10));
                if (gap > 0) begin
                    m_tready <= 1'b0;
                    repeat (gap) @(negedge aclk);
                end
                m_tready <= 1'b1;
                do @(posedge aclk); while (!m_tvalid);
            end
        end
    end

endmodule
